FILE: rtl/sjp_pkg.sv
// Package for the strict JSON two-member line parser.
// Holds shared types, status codes and character constants; no dependencies.
package sjp_pkg;

    // Widths of the payload fields and registers.
    localparam int LINE_W   = 21;
    localparam int IDMAX_W  = 8;
    localparam int CODE_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID   = 2'd1;
    localparam logic [LINE_W-1:0]    MAX_LINE_RST = 21'd65536;
    localparam logic [IDMAX_W-1:0]   MAX_ID_RST   = 8'd64;

    // Result kinds.
    localparam logic [1:0] KIND_ID     = 2'd0;
    localparam logic [1:0] KIND_CHUNK  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Line status codes.
    localparam logic [CODE_W-1:0] ST_OK          = 5'd0;
    localparam logic [CODE_W-1:0] ST_TOO_LONG    = 5'd1;
    localparam logic [CODE_W-1:0] ST_BAD_UTF8    = 5'd2;
    localparam logic [CODE_W-1:0] ST_UNEXPECTED  = 5'd3;
    localparam logic [CODE_W-1:0] ST_UNTERM_STR  = 5'd4;
    localparam logic [CODE_W-1:0] ST_CTRL_BYTE   = 5'd5;
    localparam logic [CODE_W-1:0] ST_UNTERM_ESC  = 5'd6;
    localparam logic [CODE_W-1:0] ST_BAD_ESC     = 5'd7;
    localparam logic [CODE_W-1:0] ST_SHORT_HEX   = 5'd8;
    localparam logic [CODE_W-1:0] ST_NON_HEX     = 5'd9;
    localparam logic [CODE_W-1:0] ST_HEX_RANGE   = 5'd10;
    localparam logic [CODE_W-1:0] ST_REPEAT_ID   = 5'd11;
    localparam logic [CODE_W-1:0] ST_REPEAT_CHNK = 5'd12;
    localparam logic [CODE_W-1:0] ST_UNKNOWN_MEM = 5'd13;
    localparam logic [CODE_W-1:0] ST_TRAILING    = 5'd14;
    localparam logic [CODE_W-1:0] ST_NO_ID       = 5'd15;
    localparam logic [CODE_W-1:0] ST_NO_CHUNK    = 5'd16;
    localparam logic [CODE_W-1:0] ST_EMPTY_ID    = 5'd17;
    localparam logic [CODE_W-1:0] ST_ID_TOO_LONG = 5'd18;

    // Output queue size.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // One result item as it travels through the output queue.
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data;
        logic [CODE_W-1:0]  code;
        logic [7:0]         id_len;
        logic               last;
    } t_result;

    // Results that one input beat produces: a value byte, a line status, or both.
    typedef struct packed {
        logic    byte_vld;
        t_result byte_res;
        logic    stat_vld;
        t_result stat_res;
    } t_push;

endpackage

FILE: rtl/strict_json_two_member_line_parser.sv
// Top level of the strict JSON two-member line parser.
// Depends on sjp_pkg, sjp_core and sjp_outq.
//
// Usage: raw line bytes enter on the input channel (i_in_valid/o_in_ready), one
// byte per beat with has_byte set; line_end closes the line, and a beat with
// has_byte clear may carry only the line end. Decoded value bytes of the first
// "id" and "chunk" members leave on the output channel (o_out_valid/i_out_ready)
// tagged by result_kind, followed at line end by one status beat with last set.
// Throughput is one input beat per cycle while the queue has room. A beat is
// registered in the input register, parsed there and its results written to a
// four-entry output queue, from which they are offered. A line-end beat that also
// carries a value byte produces two results; the queue drains one per cycle while
// the receiver is ready. When the receiver stalls, the queue fills and input stops
// when fewer than two entries are free. Reset clears the line state, the queue and
// sets max_line_bytes to 65536 and max_id_bytes to 64. Configuration writes via
// i_cfg_we take effect at once and belong only in idle periods.
module strict_json_two_member_line_parser
    import sjp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_has_byte,
    input  logic                 i_line_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_result_kind,
    output logic [7:0]           o_out_byte,
    output logic [CODE_W-1:0]    o_status_code,
    output logic [7:0]           o_id_length,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LINE_W-1:0]    i_cfg_data
);

    t_push   push;
    logic    room;
    t_result res;

    // Parser core with input register and line state.
    sjp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_line_end  (i_line_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push)
    );

    // Result queue toward the receiver.
    sjp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_result_kind = res.kind;
    assign o_out_byte    = res.data;
    assign o_status_code = res.code;
    assign o_id_length   = res.id_len;
    assign o_last        = res.last;

endmodule

FILE: rtl/sjp_core.sv
// Parser core: input register, line state and the single-pass parse logic.
// Depends on sjp_pkg.
module sjp_core
    import sjp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_has_byte,
    input  logic                 i_line_end,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LINE_W-1:0]    i_cfg_data,
    input  logic                 i_room,
    output t_push                o_push
);

    typedef enum logic [13:0] {
        PH_OPEN      = 14'b00000000000001,
        PH_FIRST     = 14'b00000000000010,
        PH_NAME_STR  = 14'b00000000000100,
        PH_NAME_ESC  = 14'b00000000001000,
        PH_NAME_HEX  = 14'b00000000010000,
        PH_COLON     = 14'b00000000100000,
        PH_VAL_OPEN  = 14'b00000001000000,
        PH_VAL_STR   = 14'b00000010000000,
        PH_VAL_ESC   = 14'b00000100000000,
        PH_VAL_HEX   = 14'b00001000000000,
        PH_AFTER_VAL = 14'b00010000000000,
        PH_NEXT_NAME = 14'b00100000000000,
        PH_TRAILER   = 14'b01000000000000,
        PH_ERROR     = 14'b10000000000000
    } t_phase;

    typedef enum logic [1:0] {
        MEM_NONE    = 2'd0,
        MEM_ID      = 2'd1,
        MEM_CHUNK   = 2'd2,
        MEM_UNKNOWN = 2'd3
    } t_member;

    // Name matcher states.
    localparam logic [3:0] NM_START = 4'd0;
    localparam logic [3:0] NM_I     = 4'd1;
    localparam logic [3:0] NM_ID    = 4'd2;
    localparam logic [3:0] NM_C     = 4'd3;
    localparam logic [3:0] NM_CH    = 4'd4;
    localparam logic [3:0] NM_CHU   = 4'd5;
    localparam logic [3:0] NM_CHUN  = 4'd6;
    localparam logic [3:0] NM_CHUNK = 4'd7;
    localparam logic [3:0] NM_NONE  = 4'd8;

    // UTF-8 checker states.
    localparam logic [4:0] U8_LEAD  = 5'd0;
    localparam logic [4:0] U8_BAD   = 5'd16;

    localparam logic [LINE_W-1:0] LINE_SAT = {LINE_W{1'b1}};
    localparam logic [8:0]        ID_SAT   = 9'd256;

    // Characters.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LBR   = 8'h7B;
    localparam logic [7:0] CH_RBR   = 8'h7D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Next state of the UTF-8 validity checker for one raw byte.
    function automatic logic [4:0] utf8_next(input logic [4:0] s, input logic [7:0] c);
        logic [4:0] n;
        begin
            n = U8_BAD;
            if (s[4]) begin
                n = s;
            end else begin
                unique case (s[2:0])
                    3'd0: begin
                        if (c < 8'h80) n = 5'd0;
                        else if (c >= 8'hC2 && c <= 8'hDF) n = 5'd1;
                        else if (c == 8'hE0) n = 5'd4;
                        else if (c == 8'hED) n = 5'd5;
                        else if (c >= 8'hE1 && c <= 8'hEF) n = 5'd2;
                        else if (c == 8'hF0) n = 5'd6;
                        else if (c >= 8'hF1 && c <= 8'hF3) n = 5'd3;
                        else if (c == 8'hF4) n = 5'd7;
                    end
                    3'd1, 3'd2, 3'd3: begin
                        if (c >= 8'h80 && c <= 8'hBF) n = s - 5'd1;
                    end
                    3'd4: if (c >= 8'hA0 && c <= 8'hBF) n = 5'd1;
                    3'd5: if (c >= 8'h80 && c <= 8'h9F) n = 5'd1;
                    3'd6: if (c >= 8'h90 && c <= 8'hBF) n = 5'd2;
                    3'd7: if (c >= 8'h80 && c <= 8'h8F) n = 5'd2;
                    default: n = U8_BAD;
                endcase
            end
            return n;
        end
    endfunction

    // Next state of the member name matcher for one decoded byte.
    function automatic logic [3:0] name_next(input logic [3:0] s, input logic [7:0] c);
        logic [3:0] n;
        begin
            n = NM_NONE;
            if (s == NM_START && c == 8'h69) n = NM_I;
            else if (s == NM_I && c == 8'h64) n = NM_ID;
            else if (s == NM_START && c == 8'h63) n = NM_C;
            else if (s == NM_C && c == 8'h68) n = NM_CH;
            else if (s == NM_CH && c == 8'h75) n = NM_CHU;
            else if (s == NM_CHU && c == 8'h6E) n = NM_CHUN;
            else if (s == NM_CHUN && c == 8'h6B) n = NM_CHUNK;
            return n;
        end
    endfunction

    // Input register.
    logic       r_in_vld;
    logic [7:0] r_c;
    logic       r_has;
    logic       r_end;
    logic       fire;

    assign fire       = r_in_vld && i_room;
    assign o_in_ready = !r_in_vld || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_c   <= i_data_byte;
            r_has <= i_has_byte;
            r_end <= i_line_end;
        end
    end

    // Configuration registers.
    logic [LINE_W-1:0]  r_max_line;
    logic [IDMAX_W-1:0] r_max_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= MAX_LINE_RST;
            r_max_id   <= MAX_ID_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAX_LINE) r_max_line <= i_cfg_data;
            if (i_cfg_idx == CFG_MAX_ID)   r_max_id   <= i_cfg_data[IDMAX_W-1:0];
        end
    end

    // Line state.
    t_phase             r_phase, n_phase;
    logic [CODE_W-1:0]  r_err, n_err;
    logic [1:0]         r_hcnt, n_hcnt;
    logic [15:0]        r_hacc, n_hacc;
    logic [3:0]         r_name, n_name;
    t_member            r_mem, n_mem;
    logic [1:0]         r_seen, n_seen;
    logic [8:0]         r_idcnt, n_idcnt;
    logic [LINE_W-1:0]  r_lcnt, n_lcnt;
    logic [4:0]         r_utf, n_utf;

    logic               in_value;
    logic               ws;
    logic               dec_go;
    logic [7:0]         dec_c;
    logic               fail;
    logic [CODE_W-1:0]  fail_code;
    logic [3:0]         nib;
    logic               nib_ok;
    logic [15:0]        acc_new;
    logic [CODE_W-1:0]  status;
    t_push              push;

    assign in_value = (r_phase == PH_VAL_STR) || (r_phase == PH_VAL_ESC) ||
                      (r_phase == PH_VAL_HEX);
    assign ws       = (r_c == CH_SP) || (r_c == CH_TAB);

    // Hex digit decode for the \u escape.
    always_comb begin
        nib    = 4'd0;
        nib_ok = 1'b1;
        if (r_c >= 8'h30 && r_c <= 8'h39)      nib = r_c[3:0];
        else if (r_c >= 8'h61 && r_c <= 8'h66) nib = r_c[3:0] + 4'd9;
        else if (r_c >= 8'h41 && r_c <= 8'h46) nib = r_c[3:0] + 4'd9;
        else nib_ok = 1'b0;
        acc_new = {r_hacc[11:0], nib};
    end

    // Parse one beat: advance the phase, decode, emit and build the line status.
    always_comb begin
        n_phase   = r_phase;
        n_err     = r_err;
        n_hcnt    = r_hcnt;
        n_hacc    = r_hacc;
        n_name    = r_name;
        n_mem     = r_mem;
        n_seen    = r_seen;
        n_idcnt   = r_idcnt;
        n_lcnt    = r_lcnt;
        n_utf     = r_utf;
        dec_go    = 1'b0;
        dec_c     = r_c;
        fail      = 1'b0;
        fail_code = ST_OK;
        status    = ST_OK;
        push      = '0;

        if (fire && r_has) begin
            if (r_lcnt != LINE_SAT) n_lcnt = r_lcnt + 1'b1;
            n_utf = utf8_next(r_utf, r_c);

            unique case (r_phase)
                PH_OPEN: begin
                    if (!ws) begin
                        if (r_c == CH_LBR) n_phase = PH_FIRST;
                        else begin fail = 1'b1; fail_code = ST_UNEXPECTED; end
                    end
                end
                PH_FIRST: begin
                    if (!ws) begin
                        if (r_c == CH_RBR) n_phase = PH_TRAILER;
                        else if (r_c == CH_QUOTE) n_phase = PH_NAME_STR;
                        else begin fail = 1'b1; fail_code = ST_UNEXPECTED; end
                    end
                end
                PH_NEXT_NAME: begin
                    if (!ws) begin
                        if (r_c == CH_QUOTE) n_phase = PH_NAME_STR;
                        else begin fail = 1'b1; fail_code = ST_UNEXPECTED; end
                    end
                end
                PH_COLON: begin
                    if (!ws) begin
                        if (r_c == CH_COLON) n_phase = PH_VAL_OPEN;
                        else begin fail = 1'b1; fail_code = ST_UNEXPECTED; end
                    end
                end
                PH_VAL_OPEN: begin
                    if (!ws) begin
                        if (r_c == CH_QUOTE) n_phase = PH_VAL_STR;
                        else begin fail = 1'b1; fail_code = ST_UNEXPECTED; end
                    end
                end
                PH_AFTER_VAL: begin
                    if (!ws) begin
                        if (r_c == CH_COMMA) n_phase = PH_NEXT_NAME;
                        else if (r_c == CH_RBR) n_phase = PH_TRAILER;
                        else begin fail = 1'b1; fail_code = ST_UNEXPECTED; end
                    end
                end
                PH_TRAILER: begin
                    if (!ws) begin fail = 1'b1; fail_code = ST_TRAILING; end
                end
                PH_NAME_STR, PH_VAL_STR: begin
                    if (r_c == CH_QUOTE) begin
                        if (!in_value) begin
                            // Name closed: resolve which member follows.
                            if (r_name == NM_ID) n_mem = MEM_ID;
                            else if (r_name == NM_CHUNK) n_mem = MEM_CHUNK;
                            else n_mem = MEM_UNKNOWN;
                            n_name  = NM_START;
                            n_phase = PH_COLON;
                        end else if (r_mem == MEM_ID && r_seen[0]) begin
                            fail = 1'b1; fail_code = ST_REPEAT_ID;
                        end else if (r_mem == MEM_CHUNK && r_seen[1]) begin
                            fail = 1'b1; fail_code = ST_REPEAT_CHNK;
                        end else if (r_mem == MEM_ID) begin
                            n_seen[0] = 1'b1;
                            n_mem     = MEM_NONE;
                            n_phase   = PH_AFTER_VAL;
                        end else if (r_mem == MEM_CHUNK) begin
                            n_seen[1] = 1'b1;
                            n_mem     = MEM_NONE;
                            n_phase   = PH_AFTER_VAL;
                        end else begin
                            fail = 1'b1; fail_code = ST_UNKNOWN_MEM;
                        end
                    end else if (r_c < CH_SP) begin
                        fail = 1'b1; fail_code = ST_CTRL_BYTE;
                    end else if (r_c == CH_BSL) begin
                        n_phase = in_value ? PH_VAL_ESC : PH_NAME_ESC;
                    end else begin
                        dec_go = 1'b1;
                    end
                end
                PH_NAME_ESC, PH_VAL_ESC: begin
                    n_phase = in_value ? PH_VAL_STR : PH_NAME_STR;
                    dec_go  = 1'b1;
                    unique case (r_c)
                        CH_QUOTE: dec_c = 8'h22;
                        CH_BSL:   dec_c = 8'h5C;
                        CH_SLASH: dec_c = 8'h2F;
                        8'h62:    dec_c = 8'h08;
                        8'h66:    dec_c = 8'h0C;
                        8'h6E:    dec_c = 8'h0A;
                        8'h72:    dec_c = 8'h0D;
                        8'h74:    dec_c = 8'h09;
                        8'h75: begin
                            dec_go  = 1'b0;
                            n_phase = in_value ? PH_VAL_HEX : PH_NAME_HEX;
                            n_hcnt  = 2'd0;
                            n_hacc  = 16'd0;
                        end
                        default: begin
                            dec_go = 1'b0;
                            fail = 1'b1; fail_code = ST_BAD_ESC;
                        end
                    endcase
                end
                PH_NAME_HEX, PH_VAL_HEX: begin
                    if (!nib_ok) begin
                        fail = 1'b1; fail_code = ST_NON_HEX;
                    end else begin
                        n_hacc = acc_new;
                        n_hcnt = r_hcnt + 2'd1;
                        if (r_hcnt == 2'd3) begin
                            n_phase = in_value ? PH_VAL_STR : PH_NAME_STR;
                            if (acc_new > 16'h007F) begin
                                fail = 1'b1; fail_code = ST_HEX_RANGE;
                            end else begin
                                dec_go = 1'b1;
                                dec_c  = acc_new[7:0];
                            end
                        end
                    end
                end
                PH_ERROR: begin
                end
                default: begin
                end
            endcase

            // Decoded string byte: feeds the name matcher or becomes a value byte.
            if (dec_go) begin
                if (!in_value) begin
                    n_name = name_next(r_name, dec_c);
                end else if (r_mem == MEM_ID && !r_seen[0]) begin
                    if (r_idcnt != ID_SAT) n_idcnt = r_idcnt + 9'd1;
                    push.byte_vld      = 1'b1;
                    push.byte_res.kind = KIND_ID;
                    push.byte_res.data = dec_c;
                end else if (r_mem == MEM_CHUNK && !r_seen[1]) begin
                    push.byte_vld      = 1'b1;
                    push.byte_res.kind = KIND_CHUNK;
                    push.byte_res.data = dec_c;
                end
            end

            if (fail) begin
                if (r_err == ST_OK) n_err = fail_code;
                n_phase = PH_ERROR;
            end
        end

        // Line end: report status in priority order, then clear the line state.
        if (fire && r_end) begin
            if (n_lcnt > r_max_line) status = ST_TOO_LONG;
            else if (n_utf != U8_LEAD) status = ST_BAD_UTF8;
            else if (n_err != ST_OK) status = n_err;
            else if (n_phase == PH_NAME_STR || n_phase == PH_VAL_STR) status = ST_UNTERM_STR;
            else if (n_phase == PH_NAME_ESC || n_phase == PH_VAL_ESC) status = ST_UNTERM_ESC;
            else if (n_phase == PH_NAME_HEX || n_phase == PH_VAL_HEX) status = ST_SHORT_HEX;
            else if (n_phase != PH_TRAILER) status = ST_UNEXPECTED;
            else if (!n_seen[0]) status = ST_NO_ID;
            else if (!n_seen[1]) status = ST_NO_CHUNK;
            else if (n_idcnt == 9'd0) status = ST_EMPTY_ID;
            else if (n_idcnt > {1'b0, r_max_id}) status = ST_ID_TOO_LONG;
            else status = ST_OK;

            push.stat_vld        = 1'b1;
            push.stat_res.kind   = KIND_STATUS;
            push.stat_res.code   = status;
            push.stat_res.id_len = n_idcnt[8] ? 8'hFF : n_idcnt[7:0];
            push.stat_res.last   = 1'b1;

            n_phase = PH_OPEN;
            n_err   = ST_OK;
            n_hcnt  = 2'd0;
            n_hacc  = 16'd0;
            n_name  = NM_START;
            n_mem   = MEM_NONE;
            n_seen  = 2'b00;
            n_idcnt = 9'd0;
            n_lcnt  = '0;
            n_utf   = U8_LEAD;
        end
    end

    assign o_push = push;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
            r_err   <= ST_OK;
            r_hcnt  <= 2'd0;
            r_hacc  <= 16'd0;
            r_name  <= NM_START;
            r_mem   <= MEM_NONE;
            r_seen  <= 2'b00;
            r_idcnt <= 9'd0;
            r_lcnt  <= '0;
            r_utf   <= U8_LEAD;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_hcnt  <= n_hcnt;
            r_hacc  <= n_hacc;
            r_name  <= n_name;
            r_mem   <= n_mem;
            r_seen  <= n_seen;
            r_idcnt <= n_idcnt;
            r_lcnt  <= n_lcnt;
            r_utf   <= n_utf;
        end
    end

    // The error phase is only entered with an error code recorded.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |-> (r_err != ST_OK))
        else $error("error phase without a recorded error code");

    // A held input beat keeps its payload while the queue has no room.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !i_room) |=> (r_in_vld && $stable(r_c) && $stable(r_end)))
        else $error("input register lost a stalled beat");

endmodule

FILE: rtl/sjp_outq.sv
// Output queue: takes up to two results per cycle, hands out one per beat.
// Depends on sjp_pkg.
module sjp_outq
    import sjp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_res
);

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr, r_rd;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                pop;
    logic [1:0]          npush;
    t_result             first_res;

    assign o_out_valid = (r_cnt != '0);
    assign o_res       = r_mem[r_rd];
    assign pop         = o_out_valid && i_out_ready;
    assign o_room      = (r_cnt <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign npush       = {1'b0, i_push.byte_vld} + {1'b0, i_push.stat_vld};
    assign first_res   = i_push.byte_vld ? i_push.byte_res : i_push.stat_res;

    // Storage: the first result at the write pointer, a status behind a byte next.
    always_ff @(posedge i_clk) begin
        if (npush != 2'd0) r_mem[r_wr] <= first_res;
        if (npush == 2'd2) r_mem[r_wr + 1'b1] <= i_push.stat_res;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OQ_PTR_W'(npush);
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + OQ_CNT_W'(npush) - OQ_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (npush != 2'd0) |-> o_room)
        else $error("results pushed without room");

endmodule
